@@ hdl/rac_pkg.sv @@
// Shared types, widths and codes for the resource admission controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rac_pkg;

  localparam int SLOT_W        = 6;
  localparam int SLOT_SPACE    = 64;   // slots the request field can name
  localparam int DEFAULT_SLOTS = 64;
  localparam int VRAM_W        = 20;
  localparam int RAM_W         = 24;
  localparam int THR_W         = 10;
  localparam int CNT_W         = 7;
  localparam int TALLY_W       = 32;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 4;
  localparam int IN_DATA_W     = 64;
  localparam int OUT_DATA_W    = 184;
  localparam int PADDR_W       = 5;
  localparam int PDATA_W       = 32;
  localparam int REG_IDX_W     = 3;

  // request opcodes
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_PREVIEW = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
  localparam logic [STATUS_W-1:0] ST_BAD       = 4'd1;
  localparam logic [STATUS_W-1:0] ST_UNCONF    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_EXCL_BUSY = 4'd4;
  localparam logic [STATUS_W-1:0] ST_DRAIN     = 4'd5;
  localparam logic [STATUS_W-1:0] ST_VRAM      = 4'd6;
  localparam logic [STATUS_W-1:0] ST_RAM       = 4'd7;
  localparam logic [STATUS_W-1:0] ST_CPU       = 4'd8;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 4'd9;

  // register indexes (byte address 4*index)
  localparam logic [REG_IDX_W-1:0] REG_VRAM_TOTAL   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VRAM_RESERVE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RAM_TOTAL    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RAM_RESERVE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_THREADS      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE       = 3'd5;

  typedef struct packed {
    logic             excl;
    logic [THR_W-1:0]  thr;
    logic [RAM_W-1:0]  ram;
    logic [VRAM_W-1:0] vram;
  } demand_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [VRAM_W-1:0] vram;
    logic [RAM_W-1:0]  ram;
    logic [THR_W-1:0]  thr;
    logic              excl;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VRAM_W-1:0]   proj_vram;
    logic [RAM_W-1:0]    proj_ram;
    logic [THR_W-1:0]    proj_thr;
    logic [VRAM_W-1:0]   head_vram;
    logic [RAM_W-1:0]    head_ram;
    logic [THR_W-1:0]    head_thr;
    logic                act_excl;
    logic [CNT_W-1:0]    active;
    logic                excl_held;
    logic [TALLY_W-1:0]  admits;
    logic [TALLY_W-1:0]  rejects;
  } resp_t;

  typedef struct packed {
    logic              budget_ok;
    logic [VRAM_W-1:0] vram_usable;
    logic [RAM_W-1:0]  ram_usable;
    logic [THR_W-1:0]  thr_usable;
  } cfg_t;

  typedef struct packed {
    logic              wr_en;   // store demand, mark slot active
    logic              clr;     // mark slot free
    logic [SLOT_W-1:0] slot;
    demand_t           demand;
  } slot_wr_t;

endpackage

`default_nettype wire

@@ hdl/rac_cfg_regs.sv @@
// APB register file for the budget settings; derives usable budgets.
// Depends on rac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rac_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rac_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rac_pkg::PDATA_W-1:0] pwdata,
  output logic      [rac_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output rac_pkg::cfg_t                    cfg_o
);
  import rac_pkg::*;

  logic [VRAM_W-1:0]    vram_total_q, vram_resv_q;
  logic [RAM_W-1:0]     ram_total_q, ram_resv_q;
  logic [THR_W-1:0]     threads_q;
  logic                 enable_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vram_total_q <= '0;
      vram_resv_q  <= '0;
      ram_total_q  <= '0;
      ram_resv_q   <= '0;
      threads_q    <= '0;
      enable_q     <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_VRAM_TOTAL:   vram_total_q <= pwdata[VRAM_W-1:0];
        REG_VRAM_RESERVE: vram_resv_q  <= pwdata[VRAM_W-1:0];
        REG_RAM_TOTAL:    ram_total_q  <= pwdata[RAM_W-1:0];
        REG_RAM_RESERVE:  ram_resv_q   <= pwdata[RAM_W-1:0];
        REG_THREADS:      threads_q    <= pwdata[THR_W-1:0];
        REG_ENABLE:       enable_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VRAM_TOTAL:   prdata = PDATA_W'(vram_total_q);
      REG_VRAM_RESERVE: prdata = PDATA_W'(vram_resv_q);
      REG_RAM_TOTAL:    prdata = PDATA_W'(ram_total_q);
      REG_RAM_RESERVE:  prdata = PDATA_W'(ram_resv_q);
      REG_THREADS:      prdata = PDATA_W'(threads_q);
      REG_ENABLE:       prdata = PDATA_W'(enable_q);
      default:          prdata = '0;
    endcase
  end

  // enable set, reserve must stay below total, every budget non-zero
  assign cfg_o.budget_ok   = enable_q && (vram_total_q != '0) && (ram_total_q != '0)
                             && (threads_q != '0) && (vram_resv_q < vram_total_q)
                             && (ram_resv_q < ram_total_q);
  assign cfg_o.vram_usable = vram_total_q - vram_resv_q;
  assign cfg_o.ram_usable  = ram_total_q - ram_resv_q;
  assign cfg_o.thr_usable  = threads_q;

endmodule

`default_nettype wire

@@ hdl/rac_slot_store.sv @@
// Per-slot demand memory (registered synchronous read) and active flags.
// Depends on rac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rac_slot_store #(
  parameter int SLOTS = rac_pkg::DEFAULT_SLOTS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       rd_en_i,
  input  wire logic [rac_pkg::SLOT_W-1:0] rd_slot_i,
  output rac_pkg::demand_t                rd_demand_o,
  output logic                            rd_active_o,
  input  rac_pkg::slot_wr_t               wr_i
);
  import rac_pkg::*;

  localparam int DEPTH = (SLOTS < SLOT_SPACE) ? SLOTS : SLOT_SPACE;
  localparam int AW    = $clog2(DEPTH);

  demand_t          mem [DEPTH];
  logic [DEPTH-1:0] active_q;
  logic [AW-1:0]    rd_idx, wr_idx;

  assign rd_idx = AW'(rd_slot_i);
  assign wr_idx = AW'(wr_i.slot);

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      mem[wr_idx] <= wr_i.demand;
    end
    if (rd_en_i) begin
      rd_demand_o <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      rd_active_o <= 1'b0;
    end else begin
      if (wr_i.wr_en) begin
        active_q[wr_idx] <= 1'b1;
      end else if (wr_i.clr) begin
        active_q[wr_idx] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_active_o <= active_q[rd_idx];
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/rac_engine.sv @@
// Request sequencer: slot read, checks, usage update and slot write-back,
// with the result register. Depends on rac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rac_engine #(
  parameter int SLOTS = rac_pkg::DEFAULT_SLOTS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       req_valid_i,
  output logic                            req_ready_o,
  input  rac_pkg::req_t                   req_i,
  input  rac_pkg::cfg_t                   cfg_i,
  output logic                            rd_en_o,
  output logic      [rac_pkg::SLOT_W-1:0] rd_slot_o,
  input  rac_pkg::demand_t                rd_demand_i,
  input  wire logic                       rd_active_i,
  output rac_pkg::slot_wr_t               wr_o,
  output logic                            resp_valid_o,
  input  wire logic                       resp_ready_i,
  output rac_pkg::resp_t                  resp_o
);
  import rac_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q;
  logic accept, exec;

  req_t              req_q;
  logic              in_range_q;
  logic [VRAM_W-1:0] head_vram_q;
  logic [RAM_W-1:0]  head_ram_q;
  logic [THR_W-1:0]  head_thr_q;

  logic [VRAM_W-1:0]  vram_use_q, vram_use_d;
  logic [RAM_W-1:0]   ram_use_q, ram_use_d;
  logic [THR_W-1:0]   thr_use_q, thr_use_d;
  logic [CNT_W-1:0]   gpu_users_q, gpu_users_d;
  logic [CNT_W-1:0]   active_q, active_d;
  logic               excl_q, excl_d;
  logic [TALLY_W-1:0] admits_q, admits_d, rejects_q, rejects_d;

  logic                resp_valid_q;
  resp_t               resp_q, resp_d;
  logic [STATUS_W-1:0] status;
  logic                needs_accel, commit, rel, reject;

  assign req_ready_o = (state_q == S_IDLE) && (!resp_valid_q || resp_ready_i);
  assign accept      = req_valid_i && req_ready_o;
  assign exec        = (state_q == S_EXEC);
  assign rd_en_o     = accept;
  assign rd_slot_o   = req_i.slot;

  // front stage: latch request and current headrooms while the slot is read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q       <= req_i;
      in_range_q  <= (32'(req_i.slot) < 32'(SLOTS));
      head_vram_q <= (cfg_i.budget_ok && cfg_i.vram_usable >= vram_use_q)
                     ? cfg_i.vram_usable - vram_use_q : '0;
      head_ram_q  <= (cfg_i.budget_ok && cfg_i.ram_usable >= ram_use_q)
                     ? cfg_i.ram_usable - ram_use_q : '0;
      head_thr_q  <= (cfg_i.budget_ok && cfg_i.thr_usable >= thr_use_q)
                     ? cfg_i.thr_usable - thr_use_q : '0;
    end
  end

  assign needs_accel = req_q.excl || (req_q.vram != '0);

  always_comb begin
    status              = ST_OK;
    commit              = 1'b0;
    rel                 = 1'b0;
    reject              = 1'b0;
    resp_d              = '0;
    resp_d.proj_vram    = vram_use_q;
    resp_d.proj_ram     = ram_use_q;
    resp_d.proj_thr     = thr_use_q;
    resp_d.head_vram    = head_vram_q;
    resp_d.head_ram     = head_ram_q;
    resp_d.head_thr     = head_thr_q;
    unique case (req_q.op) inside
      OP_ACQUIRE, OP_PREVIEW: begin
        if (req_q.thr == '0 || !in_range_q)            status = ST_BAD;
        else if (!cfg_i.budget_ok)                     status = ST_UNCONF;
        else if (rd_active_i)                          status = ST_EXISTS;
        else if (excl_q && needs_accel)                status = ST_EXCL_BUSY;
        else if (req_q.excl && gpu_users_q != '0)      status = ST_DRAIN;
        else if (req_q.vram > head_vram_q)             status = ST_VRAM;
        else if (req_q.ram > head_ram_q)               status = ST_RAM;
        else if (req_q.thr > head_thr_q)               status = ST_CPU;
        if (status == ST_OK) begin
          resp_d.proj_vram = vram_use_q + req_q.vram;
          resp_d.proj_ram  = ram_use_q + req_q.ram;
          resp_d.proj_thr  = thr_use_q + req_q.thr;
          resp_d.head_vram = head_vram_q - req_q.vram;
          resp_d.head_ram  = head_ram_q - req_q.ram;
          resp_d.head_thr  = head_thr_q - req_q.thr;
          resp_d.act_excl  = req_q.excl;
          commit           = (req_q.op == OP_ACQUIRE);
        end else begin
          reject = (req_q.op == OP_ACQUIRE) && (status != ST_BAD);
        end
      end
      OP_RELEASE: begin
        if (!in_range_q || !rd_active_i) begin
          status = ST_NOTFOUND;
        end else begin
          rel              = 1'b1;
          resp_d.proj_vram = vram_use_q - rd_demand_i.vram;
          resp_d.proj_ram  = ram_use_q - rd_demand_i.ram;
          resp_d.proj_thr  = thr_use_q - rd_demand_i.thr;
          resp_d.head_vram = (cfg_i.budget_ok && cfg_i.vram_usable >= resp_d.proj_vram)
                             ? cfg_i.vram_usable - resp_d.proj_vram : '0;
          resp_d.head_ram  = (cfg_i.budget_ok && cfg_i.ram_usable >= resp_d.proj_ram)
                             ? cfg_i.ram_usable - resp_d.proj_ram : '0;
          resp_d.head_thr  = (cfg_i.budget_ok && cfg_i.thr_usable >= resp_d.proj_thr)
                             ? cfg_i.thr_usable - resp_d.proj_thr : '0;
        end
      end
      default: status = ST_BAD;
    endcase

    // next shared counters
    vram_use_d  = (commit || rel) ? resp_d.proj_vram : vram_use_q;
    ram_use_d   = (commit || rel) ? resp_d.proj_ram : ram_use_q;
    thr_use_d   = (commit || rel) ? resp_d.proj_thr : thr_use_q;
    gpu_users_d = gpu_users_q;
    excl_d      = excl_q;
    active_d    = active_q;
    if (commit) begin
      if (needs_accel) gpu_users_d = gpu_users_q + CNT_W'(1);
      if (req_q.excl) excl_d = 1'b1;
      active_d = active_q + CNT_W'(1);
    end else if (rel) begin
      if ((rd_demand_i.excl || rd_demand_i.vram != '0) && gpu_users_q != '0) begin
        gpu_users_d = gpu_users_q - CNT_W'(1);
      end
      if (rd_demand_i.excl) excl_d = 1'b0;
      if (active_q != '0) active_d = active_q - CNT_W'(1);
    end
    admits_d  = commit ? admits_q + TALLY_W'(1) : admits_q;
    rejects_d = reject ? rejects_q + TALLY_W'(1) : rejects_q;

    resp_d.status    = status;
    resp_d.active    = active_d;
    resp_d.excl_held = excl_d;
    resp_d.admits    = admits_d;
    resp_d.rejects   = rejects_d;
  end

  // slot write-back lands before the next request can read
  assign wr_o.wr_en          = exec && commit;
  assign wr_o.clr            = exec && rel;
  assign wr_o.slot           = req_q.slot;
  assign wr_o.demand.excl    = req_q.excl;
  assign wr_o.demand.thr     = req_q.thr;
  assign wr_o.demand.ram     = req_q.ram;
  assign wr_o.demand.vram    = req_q.vram;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      resp_valid_q <= 1'b0;
      vram_use_q   <= '0;
      ram_use_q    <= '0;
      thr_use_q    <= '0;
      gpu_users_q  <= '0;
      active_q     <= '0;
      excl_q       <= 1'b0;
      admits_q     <= '0;
      rejects_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (accept) state_q <= S_EXEC;
        S_EXEC: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (exec) begin
        resp_valid_q <= 1'b1;
        vram_use_q   <= vram_use_d;
        ram_use_q    <= ram_use_d;
        thr_use_q    <= thr_use_d;
        gpu_users_q  <= gpu_users_d;
        active_q     <= active_d;
        excl_q       <= excl_d;
        admits_q     <= admits_d;
        rejects_q    <= rejects_d;
      end else if (resp_ready_i) begin
        resp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      resp_q <= resp_d;
    end
  end

  assign resp_valid_o = resp_valid_q;
  assign resp_o       = resp_q;

endmodule

`default_nettype wire

@@ hdl/resource_admission_controller.sv @@
// Resource admission controller: top level joining the register file, the
// slot store and the request sequencer. Depends on rac_pkg and those modules.
//
// Usage:
//  - Budgets are set through the APB port (pready always high, no wait
//    states): byte address 4*i for vram total, vram reserve, ram total,
//    ram reserve, thread budget, enable. Write only while no request is
//    in flight.
//  - A request enters on the s_axis group: tuser carries the opcode
//    (acquire, preview, release), tdata the slot and demands.
//  - Every request yields exactly one result on m_axis: tuser carries the
//    status, tdata the projected usage, headrooms, counts and tallies.
//  - The request is taken while its entry of the slot demand memory is read,
//    then checked and committed in the execute state, which loads the
//    result register. A new request is taken only after the previous one has
//    been committed, set by the read-then-write of the slot demand memory.
//  - The result register parts the two sides: a request is taken while the
//    previous result is being drained; while m_axis stalls with a result
//    pending, s_axis_tready stays low and nothing is lost.
//  - Reset clears all slots, usage, tallies and registers at once; slot
//    demand memory needs no clearing pass, an entry's demand is only used
//    when its active flag is set.
`timescale 1ns / 1ps
`default_nettype none

module resource_admission_controller #(
  parameter int SLOTS = rac_pkg::DEFAULT_SLOTS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // APB configuration
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rac_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [rac_pkg::PDATA_W-1:0]      pwdata,
  output logic      [rac_pkg::PDATA_W-1:0]      prdata,
  output logic                                  pready,
  // request stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // workload_slot, vram_mb, ram_mb, thread_demand, excl_request, zero pad
  input  wire logic [rac_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // opcode
  input  wire logic [rac_pkg::OP_W-1:0]         s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // projected_vram, projected_ram, projected_threads, vram_spare,
  // ram_spare, thread_spare, activates_exclusive, active_count,
  // exclusive_held, admission_count, rejection_count, zero pad
  output logic      [rac_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // status
  output logic      [rac_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import rac_pkg::*;

  cfg_t              cfg;
  req_t              req;
  resp_t             resp;
  demand_t           rd_demand;
  slot_wr_t          slot_wr;
  logic              rd_en, rd_active;
  logic [SLOT_W-1:0] rd_slot;

  // unpack request: fields from the lowest bit up
  assign req.op   = s_axis_tuser;
  assign req.slot = s_axis_tdata[5:0];
  assign req.vram = s_axis_tdata[25:6];
  assign req.ram  = s_axis_tdata[49:26];
  assign req.thr  = s_axis_tdata[59:50];
  assign req.excl = s_axis_tdata[60];

  rac_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rac_slot_store #(.SLOTS(SLOTS)) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rd_en),
    .rd_slot_i   (rd_slot),
    .rd_demand_o (rd_demand),
    .rd_active_o (rd_active),
    .wr_i        (slot_wr)
  );

  rac_engine #(.SLOTS(SLOTS)) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_i        (req),
    .cfg_i        (cfg),
    .rd_en_o      (rd_en),
    .rd_slot_o    (rd_slot),
    .rd_demand_i  (rd_demand),
    .rd_active_i  (rd_active),
    .wr_o         (slot_wr),
    .resp_valid_o (m_axis_tvalid),
    .resp_ready_i (m_axis_tready),
    .resp_o       (resp)
  );

  // pack result, lowest field first
  assign m_axis_tuser = resp.status;
  assign m_axis_tdata = {3'b000, resp.rejects, resp.admits, resp.excl_held, resp.active,
                         resp.act_excl, resp.head_thr, resp.head_ram, resp.head_vram,
                         resp.proj_thr, resp.proj_ram, resp.proj_vram};

endmodule

`default_nettype wire

@@ hdl/rac_checker.sv @@
// Port-level checks for the admission controller, bound to the top level.
// Depends on rac_pkg and resource_admission_controller.
`timescale 1ns / 1ps
`default_nettype none

module rac_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [rac_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire logic [rac_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import rac_pkg::*;

  // one request in flight: no request taken in the cycle after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  // a result is valid once its request has passed the execute state and the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
    else $error("result missing two cycles after request");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= ST_NOTFOUND))
    else $error("status code out of range");

  // exclusive activation only on a passing request
  a_excl_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> !m_axis_tdata[108])
    else $error("exclusive activation on failed request");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind resource_admission_controller rac_checker u_rac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ sim/resource_admission_controller_tb.sv @@
// Self-checking testbench for resource_admission_controller: drives requests and
// APB writes, predicts every result in step with the block and compares field by field.
// Depends on rac_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module resource_admission_controller_tb;
  import rac_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;    // cycles after the last result before idling ends
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [VRAM_W-1:0] VRAM_MAX = {VRAM_W{1'b1}};
  localparam logic [RAM_W-1:0]  RAM_MAX  = {RAM_W{1'b1}};
  localparam logic [THR_W-1:0]  THR_MAX  = {THR_W{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [OP_W-1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  always #1 clk_i = ~clk_i;

  resource_admission_controller dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Budget registers as last written
  logic [VRAM_W-1:0] cfg_vram_total, cfg_vram_reserve;
  logic [RAM_W-1:0]  cfg_ram_total, cfg_ram_reserve;
  logic [THR_W-1:0]  cfg_thr_budget;
  logic              cfg_enable;

  // Admission state as the block should hold it
  logic              slot_busy [SLOT_SPACE];
  demand_t           slot_claim [SLOT_SPACE];
  logic [VRAM_W-1:0] used_vram;
  logic [RAM_W-1:0]  used_ram;
  logic [THR_W-1:0]  used_thr;
  logic [CNT_W-1:0]  gpu_holders;
  logic              excl_owner;
  logic [CNT_W-1:0]  live_slots;
  logic [TALLY_W-1:0] admits_seen, rejects_seen;

  resp_t expected_verdicts [$];
  int errors = 0;
  int unsigned cycle_count = 0;
  bit no_idle = 1'b0;

  function automatic logic budget_ready();
    return cfg_enable && cfg_vram_total != 0 && cfg_ram_total != 0 && cfg_thr_budget != 0 &&
           cfg_vram_reserve < cfg_vram_total && cfg_ram_reserve < cfg_ram_total;
  endfunction

  // Usable budget left over current usage; zero while the budget is not set up
  function automatic void headroom_now(output logic [VRAM_W-1:0] hv,
                                       output logic [RAM_W-1:0] hr,
                                       output logic [THR_W-1:0] ht);
    logic [VRAM_W-1:0] uv;
    logic [RAM_W-1:0]  ur;
    hv = '0;
    hr = '0;
    ht = '0;
    if (budget_ready()) begin
      uv = cfg_vram_total - cfg_vram_reserve;
      ur = cfg_ram_total - cfg_ram_reserve;
      if (uv >= used_vram) hv = uv - used_vram;
      if (ur >= used_ram) hr = ur - used_ram;
      if (cfg_thr_budget >= used_thr) ht = cfg_thr_budget - used_thr;
    end
  endfunction

  // Verdict for one request; commits acquires and releases to the state above.
  // SLOTS equals the slot field space, so a slot is never out of range.
  function automatic resp_t judge_request(req_t rq);
    resp_t rs;
    logic [VRAM_W-1:0] hv;
    logic [RAM_W-1:0]  hr;
    logic [THR_W-1:0]  ht;
    logic [STATUS_W-1:0] st;
    logic needs_accel;
    demand_t d;
    rs = '0;
    st = ST_OK;
    needs_accel = rq.excl || (rq.vram != 0);
    headroom_now(hv, hr, ht);
    rs.proj_vram = used_vram;
    rs.proj_ram  = used_ram;
    rs.proj_thr  = used_thr;
    if (rq.op == OP_ACQUIRE || rq.op == OP_PREVIEW) begin
      if (rq.thr == 0) st = ST_BAD;
      else if (!budget_ready()) st = ST_UNCONF;
      else if (slot_busy[rq.slot]) st = ST_EXISTS;
      else if (excl_owner && needs_accel) st = ST_EXCL_BUSY;
      else if (rq.excl && gpu_holders != 0) st = ST_DRAIN;
      else if (rq.vram > hv) st = ST_VRAM;
      else if (rq.ram > hr) st = ST_RAM;
      else if (rq.thr > ht) st = ST_CPU;
      if (st == ST_OK) begin
        rs.proj_vram = used_vram + rq.vram;
        rs.proj_ram  = used_ram + rq.ram;
        rs.proj_thr  = used_thr + rq.thr;
        hv = hv - rq.vram;
        hr = hr - rq.ram;
        ht = ht - rq.thr;
        rs.act_excl = rq.excl;
        if (rq.op == OP_ACQUIRE) begin
          slot_busy[rq.slot] = 1'b1;
          d.vram = rq.vram;
          d.ram  = rq.ram;
          d.thr  = rq.thr;
          d.excl = rq.excl;
          slot_claim[rq.slot] = d;
          used_vram = rs.proj_vram;
          used_ram  = rs.proj_ram;
          used_thr  = rs.proj_thr;
          if (needs_accel) gpu_holders++;
          if (rq.excl) excl_owner = 1'b1;
          live_slots++;
          admits_seen++;
        end
      end else if (rq.op == OP_ACQUIRE && st != ST_BAD) begin
        rejects_seen++;
      end
    end else if (rq.op == OP_RELEASE) begin
      if (!slot_busy[rq.slot]) begin
        st = ST_NOTFOUND;
      end else begin
        d = slot_claim[rq.slot];
        slot_busy[rq.slot] = 1'b0;
        used_vram = used_vram - d.vram;
        used_ram  = used_ram - d.ram;
        used_thr  = used_thr - d.thr;
        if ((d.excl || d.vram != 0) && gpu_holders != 0) gpu_holders--;
        if (d.excl) excl_owner = 1'b0;
        if (live_slots != 0) live_slots--;
        rs.proj_vram = used_vram;
        rs.proj_ram  = used_ram;
        rs.proj_thr  = used_thr;
        headroom_now(hv, hr, ht);
      end
    end else begin
      st = ST_BAD;
    end
    rs.status    = st;
    rs.head_vram = hv;
    rs.head_ram  = hr;
    rs.head_thr  = ht;
    rs.active    = live_slots;
    rs.excl_held = excl_owner;
    rs.admits    = admits_seen;
    rs.rejects   = rejects_seen;
    return rs;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic req_t make_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                        logic [VRAM_W-1:0] vram, logic [RAM_W-1:0] ram,
                                        logic [THR_W-1:0] thr, logic excl);
    req_t rq;
    rq.op   = op;
    rq.slot = slot;
    rq.vram = vram;
    rq.ram  = ram;
    rq.thr  = thr;
    rq.excl = excl;
    return rq;
  endfunction

  // One request: random gap, then hold until taken. tvalid stays high on return;
  // the next call or await_quiet replaces or lowers it at the following falling edge.
  task automatic send_request(req_t rq);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {3'b000, rq.excl, rq.thr, rq.ram, rq.vram, rq.slot};
    s_axis_tuser  = rq.op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_verdicts.push_back(judge_request(rq));
  endtask

  task automatic await_quiet();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // Write one register, then read it back
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] stored;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    stored = '0;
    case (idx)
      REG_VRAM_TOTAL: begin
        cfg_vram_total = value[VRAM_W-1:0];
        stored[VRAM_W-1:0] = value[VRAM_W-1:0];
      end
      REG_VRAM_RESERVE: begin
        cfg_vram_reserve = value[VRAM_W-1:0];
        stored[VRAM_W-1:0] = value[VRAM_W-1:0];
      end
      REG_RAM_TOTAL: begin
        cfg_ram_total = value[RAM_W-1:0];
        stored[RAM_W-1:0] = value[RAM_W-1:0];
      end
      REG_RAM_RESERVE: begin
        cfg_ram_reserve = value[RAM_W-1:0];
        stored[RAM_W-1:0] = value[RAM_W-1:0];
      end
      REG_THREADS: begin
        cfg_thr_budget = value[THR_W-1:0];
        stored[THR_W-1:0] = value[THR_W-1:0];
      end
      REG_ENABLE: begin
        cfg_enable = value[0];
        stored[0] = value[0];
      end
      default: ;
    endcase
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("register readback", stored, prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Upper pwdata bits carry junk the block must drop
  task automatic set_budget(logic [VRAM_W-1:0] vt, logic [VRAM_W-1:0] vr,
                            logic [RAM_W-1:0] rt, logic [RAM_W-1:0] rr,
                            logic [THR_W-1:0] th, logic en);
    await_quiet();
    write_reg(REG_VRAM_TOTAL,   PDATA_W'({$urandom(), vt}));
    write_reg(REG_VRAM_RESERVE, PDATA_W'({$urandom(), vr}));
    write_reg(REG_RAM_TOTAL,    PDATA_W'({$urandom(), rt}));
    write_reg(REG_RAM_RESERVE,  PDATA_W'({$urandom(), rr}));
    write_reg(REG_THREADS,      PDATA_W'({$urandom(), th}));
    write_reg(REG_ENABLE,       PDATA_W'({$urandom(), en}));
  endtask

  // Registers still at reset: nothing is set up
  task automatic test_unconfigured();
    send_request(make_request(OP_ACQUIRE, 6'd0, 20'd10, 24'd10, 10'd1, 1'b0));
    send_request(make_request(OP_RELEASE, 6'd0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_UNUSED, '1, '1, '1, '1, 1'b1));
  endtask

  // Full budget, then every rejection reason but an unset budget
  task automatic test_budget_limits();
    set_budget(VRAM_MAX, '0, RAM_MAX, '0, THR_MAX, 1'b1);
    send_request(make_request(OP_ACQUIRE, 6'd0, VRAM_MAX, RAM_MAX, THR_MAX, 1'b1));
    send_request(make_request(OP_ACQUIRE, 6'd1, '0, '0, 10'd1, 1'b0));      // threads gone
    send_request(make_request(OP_ACQUIRE, 6'd0, '0, '0, 10'd1, 1'b0));      // slot taken
    send_request(make_request(OP_PREVIEW, 6'd2, 20'd1, '0, 10'd1, 1'b0));   // holder exclusive
    send_request(make_request(OP_RELEASE, 6'd0, '0, '0, '0, 1'b0));
    send_request(make_request(OP_RELEASE, 6'd0, '0, '0, '0, 1'b0));         // already free
    send_request(make_request(OP_ACQUIRE, 6'd63, 20'd1, '0, 10'd1, 1'b0));
    send_request(make_request(OP_ACQUIRE, 6'd5, '0, '0, 10'd1, 1'b1));      // must drain
    send_request(make_request(OP_PREVIEW, 6'd6, VRAM_MAX, '0, 10'd1, 1'b0));
    send_request(make_request(OP_ACQUIRE, 6'd7, '0, RAM_MAX, 10'd1, 1'b0));
    send_request(make_request(OP_PREVIEW, 6'd8, '0, 24'd1, 10'd1, 1'b0));
    send_request(make_request(OP_RELEASE, 6'd63, '1, '1, '1, 1'b1));
    send_request(make_request(OP_PREVIEW, 6'd3, '0, '0, 10'd5, 1'b1));      // passes, no commit
    send_request(make_request(OP_ACQUIRE, 6'd4, VRAM_MAX, RAM_MAX, '0, 1'b1)); // zero threads
    send_request(make_request(OP_RELEASE, 6'd7, '0, '0, '0, 1'b0));
  endtask

  // Reserve equal to total and zero threads count as not set up; release still works
  task automatic test_invalid_budgets();
    set_budget(20'd100, 20'd100, 24'd1000, '0, 10'd8, 1'b1);
    send_request(make_request(OP_ACQUIRE, 6'd9, 20'd1, 24'd1, 10'd1, 1'b0));
    set_budget(20'd100, '0, 24'd1000, 24'd1000, 10'd8, 1'b1);
    send_request(make_request(OP_PREVIEW, 6'd9, 20'd1, 24'd1, 10'd1, 1'b0));
    set_budget(20'd100, '0, 24'd1000, '0, '0, 1'b1);
    send_request(make_request(OP_PREVIEW, 6'd9, 20'd1, 24'd1, 10'd1, 1'b0));
    set_budget(20'd100, 20'd10, 24'd1000, '0, 10'd8, 1'b1);
    send_request(make_request(OP_ACQUIRE, 6'd9, 20'd90, 24'd1000, 10'd8, 1'b0)); // exact fit
    set_budget(20'd100, 20'd10, 24'd1000, '0, 10'd8, 1'b0);
    send_request(make_request(OP_RELEASE, 6'd9, '0, '0, '0, 1'b0));
  endtask

  // Mostly well-formed acquire/preview/release traffic sized to the current budget
  task automatic test_random_phase(int count);
    int unsigned vcap, rcap, tcap, kind;
    logic [63:0] noise;
    req_t rq;
    vcap = (cfg_vram_total > cfg_vram_reserve) ?
           int'(cfg_vram_total - cfg_vram_reserve) / 6 + 1 : 64;
    rcap = (cfg_ram_total > cfg_ram_reserve) ?
           int'(cfg_ram_total - cfg_ram_reserve) / 6 + 1 : 64;
    tcap = (cfg_thr_budget != 0) ? int'(cfg_thr_budget) / 6 + 1 : 16;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      noise = {$urandom(), $urandom()};
      rq = noise[62:0];
      if (kind < 52) begin
        rq.op   = (kind < 40) ? OP_ACQUIRE : OP_PREVIEW;
        rq.vram = ($urandom_range(0, 2) == 0) ? '0 : VRAM_W'($urandom_range(1, vcap));
        rq.ram  = ($urandom_range(0, 3) == 0) ? '0 : RAM_W'($urandom_range(1, rcap));
        rq.thr  = THR_W'($urandom_range(1, tcap));
        rq.excl = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 9) == 0) rq.vram = VRAM_W'($urandom());
        if ($urandom_range(0, 9) == 0) rq.ram = RAM_W'($urandom());
      end else if (kind < 88) begin
        rq.op = OP_RELEASE;   // demand fields left as junk
      end
      send_request(rq);
      // hold back until the block has answered everything
      if ($urandom_range(0, 59) == 0) await_quiet();
    end
  endtask

  task automatic test_random();
    int unsigned vt, rt, th;
    set_budget(20'd8192, 20'd1024, 24'd65536, 24'd4096, 10'd256, 1'b1);
    test_random_phase(250);
    set_budget(20'd64, '0, 24'd128, '0, 10'd16, 1'b1);
    no_idle = 1'b1;
    test_random_phase(250);
    no_idle = 1'b0;
    set_budget(VRAM_MAX, VRAM_W'(VRAM_MAX - 1), RAM_MAX, '0, THR_MAX, 1'b1);
    test_random_phase(200);
    vt = $urandom_range(1, (1 << VRAM_W) - 1);
    rt = $urandom_range(1, (1 << RAM_W) - 1);
    th = $urandom_range(1, (1 << THR_W) - 1);
    set_budget(VRAM_W'(vt), VRAM_W'($urandom_range(0, vt - 1)),
               RAM_W'(rt), RAM_W'($urandom_range(0, rt - 1)), THR_W'(th), 1'b1);
    test_random_phase(250);
    set_budget(VRAM_W'(vt), '0, RAM_W'(rt), '0, THR_W'(th), 1'b0);
    test_random_phase(100);
    set_budget(20'd500, 20'd500, 24'd500, '0, 10'd32, 1'b1);
    test_random_phase(50);
    set_budget(20'd2000, 20'd100, 24'd4000, 24'd10, 10'd40, 1'b1);
    test_random_phase(200);
  endtask

  // Result side: random stall per result, compare against the oldest prediction
  initial begin : result_monitor
    int stall;
    resp_t got, want;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.status = m_axis_tuser;
      {got.rejects, got.admits, got.excl_held, got.active, got.act_excl, got.head_thr,
       got.head_ram, got.head_vram, got.proj_thr, got.proj_ram, got.proj_vram}
        = m_axis_tdata[180:0];
      if (expected_verdicts.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        check_field("status", want.status, got.status);
        check_field("projected_vram", want.proj_vram, got.proj_vram);
        check_field("projected_ram", want.proj_ram, got.proj_ram);
        check_field("projected_threads", want.proj_thr, got.proj_thr);
        check_field("vram_spare", want.head_vram, got.head_vram);
        check_field("ram_spare", want.head_ram, got.head_ram);
        check_field("thread_spare", want.head_thr, got.head_thr);
        check_field("activates_exclusive", want.act_excl, got.act_excl);
        check_field("active_count", want.active, got.active);
        check_field("exclusive_held", want.excl_held, got.excl_held);
        check_field("admission_count", want.admits, got.admits);
        check_field("rejection_count", want.rejects, got.rejects);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[resource_admission_controller] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_vram_total = '0;
    cfg_vram_reserve = '0;
    cfg_ram_total = '0;
    cfg_ram_reserve = '0;
    cfg_thr_budget = '0;
    cfg_enable = 1'b0;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    foreach (slot_claim[i]) slot_claim[i] = '0;
    used_vram = '0;
    used_ram = '0;
    used_thr = '0;
    gpu_holders = '0;
    excl_owner = 1'b0;
    live_slots = '0;
    admits_seen = '0;
    rejects_seen = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_unconfigured();
    test_budget_limits();
    test_invalid_budgets();
    test_random();

    await_quiet();
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0) begin
      $display("[resource_admission_controller] OK");
    end else begin
      $display("[resource_admission_controller] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rac_pkg.sv
hdl/rac_cfg_regs.sv
hdl/rac_slot_store.sv
hdl/rac_engine.sv
hdl/resource_admission_controller.sv
hdl/rac_checker.sv
sim/resource_admission_controller_tb.sv
